### rtl/core/dpec_pkg.sv
package dpec_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int UNIT_SHIFT = 28;
  localparam int SQRT_LAT   = 31;
  localparam int DIV_LAT    = UNIT_SHIFT + 1;
  localparam int SIDE_LAT   = SQRT_LAT + DIV_LAT;

  localparam logic [30:0] CONTACT_RESET = 31'(1) << FRAC_BITS;

  typedef struct packed {
    logic signed [31:0] pos_a_x;
    logic signed [31:0] pos_a_y;
    logic signed [31:0] vel_a_x;
    logic signed [31:0] vel_a_y;
    logic signed [31:0] pos_b_x;
    logic signed [31:0] pos_b_y;
    logic signed [31:0] vel_b_x;
    logic signed [31:0] vel_b_y;
  } in_item_t;

  typedef struct packed {
    logic               hit;
    logic signed [31:0] new_vel_a_x;
    logic signed [31:0] new_vel_a_y;
    logic signed [31:0] new_vel_b_x;
    logic signed [31:0] new_vel_b_y;
  } out_item_t;

  typedef struct packed {
    logic               valid;
    logic               hit;
    logic               zero;
    logic               sx;
    logic               sy;
    logic [30:0]        ax;
    logic [30:0]        ay;
    logic signed [32:0] wx;
    logic signed [32:0] wy;
    logic signed [31:0] vax;
    logic signed [31:0] vay;
    logic signed [31:0] vbx;
    logic signed [31:0] vby;
  } side_t;

  function automatic logic signed [35:0] rnd_shift(input logic signed [63:0] v);
    logic [63:0] m;
    logic [63:0] q;
    m = v[63] ? 64'(-v) : 64'(v);
    q = (m + (64'(1) << (UNIT_SHIFT - 1))) >> UNIT_SHIFT;
    return v[63] ? -$signed(q[35:0]) : $signed(q[35:0]);
  endfunction

  function automatic logic signed [31:0] sat32(input logic signed [36:0] v);
    if (v > 37'sd2147483647) begin
      return 32'sh7FFFFFFF;
    end else if (v < -37'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

endpackage

### rtl/core/disc_pair_elastic_collision.sv
// Equal-mass elastic collision of two discs in Q16.16. Each item carries both
// discs; when the centre distance is below the contact distance the velocity
// components along the line of centres are exchanged, otherwise the
// velocities pass through with hit low. One item is accepted every clock
// cycle while the output is not stalled; the 31-step square-root pipeline
// and the 29-step pipelined dividers build the unit normal. A stall on the
// output holds the whole pipeline. The contact distance may be rewritten
// only while no item is in flight.
module disc_pair_elastic_collision
  import dpec_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [30:0] cfg_data_i
);

  logic        en;
  logic [30:0] cfg_q;

  side_t              s1_q, s2_q, s3_q, s4_q;
  logic signed [32:0] dx_q, dy_q;
  logic [31:0]        ax_q, ay_q;
  logic               near_q;
  logic [61:0]        sqx_q, sqy_q, cc_q;
  logic [62:0]        d2;
  logic [61:0]        rad_q;
  side_t              side_q [0:SIDE_LAT-1];
  logic [30:0]        len;
  logic [UNIT_SHIFT:0] qx, qy;

  side_t              n_side_q, p_side_q, s_side_q, m_side_q, v_side_q;
  logic signed [29:0] nx_q, ny_q, pnx_q, pny_q, snx_q, sny_q;
  logic signed [62:0] px_q, py_q;
  logic signed [35:0] pr_q, dvx_q, dvy_q;
  logic signed [63:0] mx_q, my_q;
  logic signed [65:0] mxf, myf;

  logic      out_valid_q;
  out_item_t out_q;

  assign en          = !out_valid_q || out_ready_i;
  assign in_ready_o  = en;
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= CONTACT_RESET;
    end else if (cfg_valid_i) begin
      cfg_q <= cfg_data_i;
    end
  end

  always_comb begin
    d2 = {1'b0, sqx_q} + {1'b0, sqy_q};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q.valid <= 1'b0;
      s2_q.valid <= 1'b0;
      s3_q.valid <= 1'b0;
      s4_q.valid <= 1'b0;
    end else if (en) begin
      s1_q.valid <= in_valid_i;
      s2_q.valid <= s1_q.valid;
      s3_q.valid <= s2_q.valid;
      s4_q.valid <= s3_q.valid;

      dx_q <= {in_data_i.pos_b_x[31], in_data_i.pos_b_x}
            - {in_data_i.pos_a_x[31], in_data_i.pos_a_x};
      dy_q <= {in_data_i.pos_b_y[31], in_data_i.pos_b_y}
            - {in_data_i.pos_a_y[31], in_data_i.pos_a_y};
      s1_q.hit  <= 1'b0;
      s1_q.zero <= 1'b0;
      s1_q.sx   <= 1'b0;
      s1_q.sy   <= 1'b0;
      s1_q.ax   <= '0;
      s1_q.ay   <= '0;
      s1_q.wx   <= {in_data_i.vel_b_x[31], in_data_i.vel_b_x}
                 - {in_data_i.vel_a_x[31], in_data_i.vel_a_x};
      s1_q.wy   <= {in_data_i.vel_b_y[31], in_data_i.vel_b_y}
                 - {in_data_i.vel_a_y[31], in_data_i.vel_a_y};
      s1_q.vax  <= in_data_i.vel_a_x;
      s1_q.vay  <= in_data_i.vel_a_y;
      s1_q.vbx  <= in_data_i.vel_b_x;
      s1_q.vby  <= in_data_i.vel_b_y;

      ax_q <= dx_q[32] ? 32'(-dx_q) : dx_q[31:0];
      ay_q <= dy_q[32] ? 32'(-dy_q) : dy_q[31:0];
      s2_q.hit  <= s1_q.hit;
      s2_q.zero <= s1_q.zero;
      s2_q.sx   <= dx_q[32];
      s2_q.sy   <= dy_q[32];
      s2_q.ax   <= s1_q.ax;
      s2_q.ay   <= s1_q.ay;
      s2_q.wx   <= s1_q.wx;
      s2_q.wy   <= s1_q.wy;
      s2_q.vax  <= s1_q.vax;
      s2_q.vay  <= s1_q.vay;
      s2_q.vbx  <= s1_q.vbx;
      s2_q.vby  <= s1_q.vby;

      near_q <= (ax_q < {1'b0, cfg_q}) && (ay_q < {1'b0, cfg_q});
      sqx_q  <= ax_q[30:0] * ax_q[30:0];
      sqy_q  <= ay_q[30:0] * ay_q[30:0];
      cc_q   <= cfg_q * cfg_q;
      s3_q.hit  <= s2_q.hit;
      s3_q.zero <= s2_q.zero;
      s3_q.sx   <= s2_q.sx;
      s3_q.sy   <= s2_q.sy;
      s3_q.ax   <= ax_q[30:0];
      s3_q.ay   <= ay_q[30:0];
      s3_q.wx   <= s2_q.wx;
      s3_q.wy   <= s2_q.wy;
      s3_q.vax  <= s2_q.vax;
      s3_q.vay  <= s2_q.vay;
      s3_q.vbx  <= s2_q.vbx;
      s3_q.vby  <= s2_q.vby;

      rad_q     <= d2[61:0];
      s4_q.hit  <= near_q && (d2 < {1'b0, cc_q});
      s4_q.zero <= d2 == '0;
      s4_q.sx   <= s3_q.sx;
      s4_q.sy   <= s3_q.sy;
      s4_q.ax   <= s3_q.ax;
      s4_q.ay   <= s3_q.ay;
      s4_q.wx   <= s3_q.wx;
      s4_q.wy   <= s3_q.wy;
      s4_q.vax  <= s3_q.vax;
      s4_q.vay  <= s3_q.vay;
      s4_q.vbx  <= s3_q.vbx;
      s4_q.vby  <= s3_q.vby;
    end
  end

  dpec_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (en),
    .rad_i  (rad_q),
    .root_o (len)
  );

  for (genvar g = 0; g < SIDE_LAT; g++) begin : g_side
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        side_q[g].valid <= 1'b0;
      end else if (en) begin
        if (g == 0) begin
          side_q[g] <= s4_q;
        end else begin
          side_q[g] <= side_q[(g == 0) ? 0 : g-1];
        end
      end
    end
  end

  dpec_div u_div_x (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (side_q[SQRT_LAT-1].ax),
    .den_i (len),
    .quo_o (qx)
  );

  dpec_div u_div_y (
    .clk_i (clk_i),
    .en_i  (en),
    .num_i (side_q[SQRT_LAT-1].ay),
    .den_i (len),
    .quo_o (qy)
  );

  assign mxf = pr_q * snx_q;
  assign myf = pr_q * sny_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      n_side_q.valid <= 1'b0;
      p_side_q.valid <= 1'b0;
      s_side_q.valid <= 1'b0;
      m_side_q.valid <= 1'b0;
      v_side_q.valid <= 1'b0;
      out_valid_q    <= 1'b0;
    end else if (en) begin
      out_valid_q <= v_side_q.valid;

      n_side_q <= side_q[SIDE_LAT-1];
      if (side_q[SIDE_LAT-1].zero) begin
        nx_q <= 30'sd1 <<< UNIT_SHIFT;
        ny_q <= '0;
      end else begin
        nx_q <= side_q[SIDE_LAT-1].sx ? -$signed({1'b0, qx}) : $signed({1'b0, qx});
        ny_q <= side_q[SIDE_LAT-1].sy ? -$signed({1'b0, qy}) : $signed({1'b0, qy});
      end

      p_side_q <= n_side_q;
      px_q  <= n_side_q.wx * nx_q;
      py_q  <= n_side_q.wy * ny_q;
      pnx_q <= nx_q;
      pny_q <= ny_q;

      s_side_q <= p_side_q;
      pr_q  <= rnd_shift(64'(px_q) + 64'(py_q));
      snx_q <= pnx_q;
      sny_q <= pny_q;

      m_side_q <= s_side_q;
      mx_q <= mxf[63:0];
      my_q <= myf[63:0];

      v_side_q <= m_side_q;
      dvx_q <= rnd_shift(mx_q);
      dvy_q <= rnd_shift(my_q);

      out_q.hit <= v_side_q.hit;
      if (v_side_q.hit) begin
        out_q.new_vel_a_x <= sat32(37'(v_side_q.vax) + 37'(dvx_q));
        out_q.new_vel_a_y <= sat32(37'(v_side_q.vay) + 37'(dvy_q));
        out_q.new_vel_b_x <= sat32(37'(v_side_q.vbx) - 37'(dvx_q));
        out_q.new_vel_b_y <= sat32(37'(v_side_q.vby) - 37'(dvy_q));
      end else begin
        out_q.new_vel_a_x <= v_side_q.vax;
        out_q.new_vel_a_y <= v_side_q.vay;
        out_q.new_vel_b_x <= v_side_q.vbx;
        out_q.new_vel_b_y <= v_side_q.vby;
      end
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### rtl/core/dpec_sqrt.sv
module dpec_sqrt
  import dpec_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [61:0] rad_i,
  output logic [30:0] root_o
);

  logic [62:0] rem_q  [0:SQRT_LAT];
  logic [30:0] root_q [0:SQRT_LAT];

  assign rem_q[0]  = {1'b0, rad_i};
  assign root_q[0] = '0;

  for (genvar g = 0; g < SQRT_LAT; g++) begin : g_step
    localparam int B = SQRT_LAT - 1 - g;
    logic [62:0] trial;
    assign trial = ({32'b0, root_q[g]} << (B + 1)) + (63'(1) << (2 * B));
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        if (rem_q[g] >= trial) begin
          rem_q[g+1]  <= rem_q[g] - trial;
          root_q[g+1] <= root_q[g] | (31'(1) << B);
        end else begin
          rem_q[g+1]  <= rem_q[g];
          root_q[g+1] <= root_q[g];
        end
      end
    end
  end

  assign root_o = root_q[SQRT_LAT];

endmodule

### rtl/core/dpec_div.sv
module dpec_div
  import dpec_pkg::*;
(
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [30:0] num_i,
  input  logic [30:0] den_i,
  output logic [UNIT_SHIFT:0] quo_o
);

  logic [30:0]         rem_q [0:DIV_LAT];
  logic [30:0]         den_q [0:DIV_LAT];
  logic [UNIT_SHIFT:0] quo_q [0:DIV_LAT];

  assign rem_q[0] = num_i;
  assign den_q[0] = den_i;
  assign quo_q[0] = '0;

  for (genvar g = 0; g < DIV_LAT; g++) begin : g_step
    logic [31:0] t;
    logic        qb;
    if (g == 0) begin : g_first
      assign t = {1'b0, rem_q[g]};
    end else begin : g_rest
      assign t = {rem_q[g], 1'b0};
    end
    assign qb = t >= {1'b0, den_q[g]};
    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[g+1] <= qb ? 31'(t - {1'b0, den_q[g]}) : t[30:0];
        den_q[g+1] <= den_q[g];
        quo_q[g+1] <= {quo_q[g][UNIT_SHIFT-1:0], qb};
      end
    end
  end

  assign quo_o = quo_q[DIV_LAT];

endmodule

### rtl/core/dpec_checker.sv
module dpec_checker
  import dpec_pkg::*;
(
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_o,
  input logic        out_valid_o,
  input logic        out_ready_i,
  input out_item_t   out_data_o,
  input logic        cfg_valid_i,
  input logic        cfg_ready_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o))
    else $error("Output item changed while stalled.");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o || out_ready_i |-> in_ready_o)
    else $error("Input not ready although the output can move.");

  a_stall_blocks_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |-> !in_ready_o)
    else $error("Input accepted while the output is stalled.");

  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("Configuration write refused.");

endmodule

bind disc_pair_elastic_collision dpec_checker u_dpec_checker (.*);
